### design/sbeu_pkg.sv
// ----------------------------------------------------------------------------
// sbeu_pkg
// Shared types, opcodes and constants of the stack bytecode execute unit.
// ----------------------------------------------------------------------------
package sbeu_pkg;

  localparam int STACK_DEPTH_DEF  = 256;
  localparam int LOCALS_DEF       = 256;
  localparam int GLOBALS_DEF      = 256;
  localparam int CALL_DEPTH_DEF   = 8;

  localparam logic [63:0] GLOBAL_BASE = 64'd256;
  localparam int LIDX_W = 8;
  localparam int GIDX_W = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 112;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_START   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART = 1'd1;

  localparam logic [5:0] OP_GDECL   = 6'd0;
  localparam logic [5:0] OP_LDECL   = 6'd1;
  localparam logic [5:0] OP_STORE   = 6'd2;
  localparam logic [5:0] OP_LOAD    = 6'd3;
  localparam logic [5:0] OP_BITTEST = 6'd4;
  localparam logic [5:0] OP_PUSH    = 6'd5;
  localparam logic [5:0] OP_JMP     = 6'd6;
  localparam logic [5:0] OP_JT      = 6'd7;
  localparam logic [5:0] OP_JF      = 6'd8;
  localparam logic [5:0] OP_CALL    = 6'd9;
  localparam logic [5:0] OP_RET     = 6'd10;
  localparam logic [5:0] OP_INC     = 6'd11;
  localparam logic [5:0] OP_DEC     = 6'd12;
  localparam logic [5:0] OP_ADD     = 6'd13;
  localparam logic [5:0] OP_SUB     = 6'd14;
  localparam logic [5:0] OP_MUL     = 6'd15;
  localparam logic [5:0] OP_DIV     = 6'd16;
  localparam logic [5:0] OP_MOD     = 6'd17;
  localparam logic [5:0] OP_LT      = 6'd18;
  localparam logic [5:0] OP_LE      = 6'd19;
  localparam logic [5:0] OP_GT      = 6'd20;
  localparam logic [5:0] OP_GE      = 6'd21;
  localparam logic [5:0] OP_EQ      = 6'd22;
  localparam logic [5:0] OP_NE      = 6'd23;
  localparam logic [5:0] OP_SHL     = 6'd24;
  localparam logic [5:0] OP_SHR     = 6'd25;
  localparam logic [5:0] OP_OR      = 6'd26;
  localparam logic [5:0] OP_AND     = 6'd27;
  localparam logic [5:0] OP_XOR     = 6'd28;
  localparam logic [5:0] OP_LNOT    = 6'd29;
  localparam logic [5:0] OP_BNOT    = 6'd30;
  localparam logic [5:0] OP_NORET   = 6'd31;
  localparam logic [5:0] OP_DROP    = 6'd32;

  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_OVER   = 3'd1;
  localparam logic [2:0] ERR_UNDER  = 3'd2;
  localparam logic [2:0] ERR_DIVZ   = 3'd3;
  localparam logic [2:0] ERR_CDEPTH = 3'd4;
  localparam logic [2:0] ERR_INDEX  = 3'd5;

  typedef struct packed {
    logic [5:0]        op;
    logic [63:0]       operand;
    logic              is_array;
    logic [31:0]       next_address;
    logic              var_local;
    logic              var_ok;
    logic              decl_ok;
    logic [LIDX_W-1:0] lidx;
    logic [GIDX_W-1:0] gidx;
  } item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [63:0] top_value;
    logic [8:0]  stack_depth;
    logic        halted;
    logic [2:0]  error_code;
  } res_t;

endpackage

### design/sbeu_front.sv
// ----------------------------------------------------------------------------
// sbeu_front
// Accepts instruction transactions and classifies the variable index.
// ----------------------------------------------------------------------------
module sbeu_front #(
  parameter int LOCALS_PER_FRAME = sbeu_pkg::LOCALS_DEF,
  parameter int GLOBAL_SLOTS     = sbeu_pkg::GLOBALS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sbeu_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  output logic                           q_valid,
  input  logic                           q_ready,
  output sbeu_pkg::item_t                q_item
);

  logic            fv;
  sbeu_pkg::item_t fitem;
  sbeu_pkg::item_t dec;
  logic [63:0]     gofs;

  always_comb begin
    dec              = '0;
    dec.op           = s_tdata[5:0];
    dec.operand      = s_tdata[69:6];
    dec.next_address = s_tdata[101:70];
    dec.is_array     = s_tuser;
    gofs             = dec.operand - sbeu_pkg::GLOBAL_BASE;
    dec.var_local    = dec.operand < sbeu_pkg::GLOBAL_BASE;
    dec.var_ok       = dec.var_local ? (dec.operand < 64'(LOCALS_PER_FRAME))
                                     : (gofs < 64'(GLOBAL_SLOTS));
    dec.decl_ok      = dec.var_ok && ((dec.op == sbeu_pkg::OP_GDECL) == !dec.var_local);
    dec.lidx         = dec.operand[sbeu_pkg::LIDX_W-1:0];
    dec.gidx         = gofs[sbeu_pkg::GIDX_W-1:0];
  end

  assign s_tready = !fv || q_ready;
  assign q_valid  = fv;
  assign q_item   = fitem;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tready) begin
      fv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      fitem <= dec;
    end
  end

endmodule

### design/sbeu_queue.sv
// ----------------------------------------------------------------------------
// sbeu_queue
// Short queue of classified instructions between front and back.
// ----------------------------------------------------------------------------
module sbeu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sbeu_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output sbeu_pkg::item_t out_item
);

  localparam int PW = $clog2(sbeu_pkg::QUEUE_DEPTH);

  sbeu_pkg::item_t   slots [sbeu_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;
  logic              push;
  logic              pop;

  assign in_ready  = count != (PW+1)'(sbeu_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(sbeu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(sbeu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

### design/sbeu_muldiv.sv
// ----------------------------------------------------------------------------
// sbeu_muldiv
// Multi-cycle 64-bit multiplier (three 32x32 partial products) and
// restoring unsigned divider (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module sbeu_muldiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        is_mul,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res_lo,
  output logic [63:0] res_hi
);

  logic        busy;
  logic        mul_mode;
  logic [5:0]  cnt;
  logic [63:0] opa;
  logic [63:0] opb;
  logic [63:0] acc;
  logic [63:0] quo;
  logic [63:0] rem;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] prod;
  logic [64:0] rem_sh;
  logic [64:0] diff;

  always_comb begin
    mx = opa[31:0];
    my = opb[31:0];
    case (cnt[1:0])
      2'd1:    my = opb[63:32];
      2'd2:    mx = opa[63:32];
      default: ;
    endcase
    prod   = mx * my;
    rem_sh = {rem, quo[63]};
    diff   = rem_sh - {1'b0, opb};
  end

  assign res_lo = mul_mode ? acc : quo;
  assign res_hi = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy) begin
        if ((mul_mode && cnt == 6'd2) || (!mul_mode && cnt == 6'd63)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mul_mode <= is_mul;
      opa      <= a;
      opb      <= b;
      acc      <= '0;
      quo      <= a;
      rem      <= '0;
      cnt      <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (mul_mode) begin
        acc <= acc + ((cnt == 6'd0) ? prod : {prod[31:0], 32'd0});
      end else if (!diff[64]) begin
        rem <= diff[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh[63:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

endmodule

### design/sbeu_back.sv
// ----------------------------------------------------------------------------
// sbeu_back
// Execution sequencer: operand stack, locals, globals, return stack,
// control flow and result register.
// ----------------------------------------------------------------------------
module sbeu_back #(
  parameter int STACK_DEPTH      = sbeu_pkg::STACK_DEPTH_DEF,
  parameter int LOCALS_PER_FRAME = sbeu_pkg::LOCALS_DEF,
  parameter int GLOBAL_SLOTS     = sbeu_pkg::GLOBALS_DEF,
  parameter int CALL_DEPTH       = sbeu_pkg::CALL_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  sbeu_pkg::item_t                 q_item,
  input  logic                            cfg_we,
  input  logic [sbeu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbeu_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            res_valid,
  input  logic                            res_ready,
  output sbeu_pkg::res_t                  res
);

  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int LIW   = $clog2(LOCALS_PER_FRAME);
  localparam int GIW   = $clog2(GLOBAL_SLOTS);
  localparam int LVW   = $clog2(CALL_DEPTH);
  localparam int LAW   = $clog2(CALL_DEPTH * LOCALS_PER_FRAME);
  localparam int SWEEP = (LOCALS_PER_FRAME > GLOBAL_SLOTS) ? LOCALS_PER_FRAME : GLOBAL_SLOTS;
  localparam int CNTW  = $clog2(SWEEP);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_MD    = 5'b01000,
    ST_CLEAR = 5'b10000
  } state_t;

  state_t          state;
  sbeu_pkg::item_t cur;
  logic [SPW-1:0]  sp;
  logic [63:0]     tos;
  logic [LVW-1:0]  level;
  logic [CALL_DEPTH-1:0] noret;
  logic [31:0]     pc;
  logic [31:0]     start_addr;
  logic [31:0]     restart_addr;
  logic            halted;
  logic            has_run;
  logic            md_have;
  logic [CNTW-1:0] cnt;
  logic            clr_glob;
  logic [LVW-1:0]  clr_level;

  logic [63:0] stk_mem [STACK_DEPTH];
  logic [64:0] loc_mem [CALL_DEPTH * LOCALS_PER_FRAME];
  logic [64:0] glb_mem [GLOBAL_SLOTS];
  logic [31:0] ret_mem [CALL_DEPTH];
  logic [63:0] stk_rd;
  logic [64:0] loc_rd;
  logic [64:0] glb_rd;
  logic [31:0] ret_rd;

  logic        md_start;
  logic        md_done;
  logic [63:0] md_lo;
  logic [63:0] md_hi;
  logic        md_is_mul;
  logic [63:0] md_a;
  logic [63:0] md_b;

  logic [2:0]     err;
  logic [31:0]    npc;
  logic [SPW-1:0] sp_n;
  logic [63:0]    tos_n;
  logic [LVW-1:0] lvl_n;
  logic           halt_n;
  logic           push_we;
  logic           var_we;
  logic [64:0]    var_wd;
  logic           ret_we;
  logic           clr_go;
  logic [LVW-1:0] clr_lvl_c;
  logic           nr_set;
  logic           nr_clr;
  logic [LVW-1:0] nr_idx;
  logic           md_op;
  logic           commit;
  logic           out_free;
  logic [63:0]    a;
  logic [63:0]    b;
  logic [63:0]    var_val;
  logic           var_flag;
  logic [63:0]    r;
  logic [63:0]    target;
  logic           sp_ge1;
  logic           sp_ge2;
  logic           sp_full;
  logic           at_top;
  logic [LAW-1:0] loc_ra;
  logic [LAW-1:0] loc_ca;
  logic           loc_we;
  logic [LAW-1:0] loc_wa;
  logic           glb_we;
  logic [GIW-1:0] glb_wa;
  logic           clr_loc_on;
  logic           clr_glb_on;
  logic           clr_end;

  function automatic logic [LAW-1:0] loc_addr(input logic [LVW-1:0] lv,
                                              input logic [LIW-1:0] ix);
    return LAW'(lv) * LAW'(LOCALS_PER_FRAME) + LAW'(ix);
  endfunction

  assign a        = stk_rd;
  assign b        = tos;
  assign var_val  = cur.var_local ? loc_rd[63:0] : glb_rd[63:0];
  assign var_flag = cur.var_local ? loc_rd[64] : glb_rd[64];
  assign target   = {32'd0, cur.operand[31:0]};
  assign sp_ge1   = sp != '0;
  assign sp_ge2   = sp >= SPW'(2);
  assign sp_full  = sp == SPW'(STACK_DEPTH);
  assign at_top   = ({1'b0, level} + (LVW+1)'(1)) >= (LVW+1)'(CALL_DEPTH);
  assign loc_ra   = loc_addr(level, cur.lidx[LIW-1:0]);
  assign loc_ca   = loc_addr(clr_level, LIW'(cnt));
  assign out_free = !res_valid || res_ready;
  assign q_ready  = state == ST_IDLE;

  assign md_is_mul = cur.op == sbeu_pkg::OP_MUL;
  assign md_a      = (md_is_mul || !a[63]) ? a : (64'd0 - a);
  assign md_b      = (md_is_mul || !b[63]) ? b : (64'd0 - b);

  always_comb begin
    err       = sbeu_pkg::ERR_OK;
    npc       = cur.next_address;
    sp_n      = sp;
    tos_n     = tos;
    lvl_n     = level;
    halt_n    = halted;
    push_we   = 1'b0;
    var_we    = 1'b0;
    var_wd    = {var_flag, var_val};
    ret_we    = 1'b0;
    clr_go    = 1'b0;
    clr_lvl_c = level;
    nr_set    = 1'b0;
    nr_clr    = 1'b0;
    nr_idx    = level;
    md_op     = 1'b0;
    r         = '0;
    if (halted) begin
      npc = pc;
    end else begin
      case (cur.op)
        sbeu_pkg::OP_GDECL, sbeu_pkg::OP_LDECL: begin
          if (!cur.decl_ok) begin
            err = sbeu_pkg::ERR_INDEX;
          end else begin
            var_we = 1'b1;
            var_wd = {cur.is_array, 64'd0};
          end
        end
        sbeu_pkg::OP_STORE: begin
          if (!cur.var_ok) begin
            err = sbeu_pkg::ERR_INDEX;
          end else if (!sp_ge1) begin
            err = sbeu_pkg::ERR_UNDER;
          end else begin
            var_we = 1'b1;
            var_wd = {var_flag, tos};
            sp_n   = sp - 1'b1;
            tos_n  = a;
          end
        end
        sbeu_pkg::OP_LOAD: begin
          if (!cur.var_ok) begin
            err = sbeu_pkg::ERR_INDEX;
          end else if (sp_full) begin
            err = sbeu_pkg::ERR_OVER;
          end else begin
            push_we = 1'b1;
            tos_n   = var_val;
            sp_n    = sp + 1'b1;
          end
        end
        sbeu_pkg::OP_BITTEST: begin
          if (!cur.var_ok || var_flag) begin
            err = sbeu_pkg::ERR_INDEX;
          end else if (!sp_ge1) begin
            err = sbeu_pkg::ERR_UNDER;
          end else begin
            tos_n = {63'd0, var_val[tos[5:0]]};
          end
        end
        sbeu_pkg::OP_PUSH: begin
          if (sp_full) begin
            err = sbeu_pkg::ERR_OVER;
          end else begin
            push_we = 1'b1;
            tos_n   = cur.operand;
            sp_n    = sp + 1'b1;
          end
        end
        sbeu_pkg::OP_JMP: begin
          npc = target[31:0];
        end
        sbeu_pkg::OP_JT, sbeu_pkg::OP_JF: begin
          if (!sp_ge1) begin
            err = sbeu_pkg::ERR_UNDER;
          end else begin
            sp_n  = sp - 1'b1;
            tos_n = a;
            if ((cur.op == sbeu_pkg::OP_JT) == (tos != 64'd0)) begin
              npc = target[31:0];
            end
          end
        end
        sbeu_pkg::OP_CALL: begin
          if (at_top) begin
            err = sbeu_pkg::ERR_CDEPTH;
          end else begin
            ret_we    = 1'b1;
            lvl_n     = level + 1'b1;
            clr_go    = 1'b1;
            clr_lvl_c = level + 1'b1;
            nr_clr    = 1'b1;
            nr_idx    = level + 1'b1;
            npc       = target[31:0];
          end
        end
        sbeu_pkg::OP_RET: begin
          if (noret[level]) begin
            clr_go = 1'b1;
            nr_clr = 1'b1;
            npc    = restart_addr;
          end else if (level == '0) begin
            halt_n = 1'b1;
            npc    = pc;
          end else begin
            lvl_n = level - 1'b1;
            npc   = ret_rd;
          end
        end
        sbeu_pkg::OP_INC, sbeu_pkg::OP_DEC: begin
          if (!cur.var_ok) begin
            err = sbeu_pkg::ERR_INDEX;
          end else begin
            var_we = 1'b1;
            var_wd = {var_flag, (cur.op == sbeu_pkg::OP_INC) ? var_val + 64'd1
                                                             : var_val - 64'd1};
          end
        end
        sbeu_pkg::OP_LNOT, sbeu_pkg::OP_BNOT: begin
          if (!sp_ge1) begin
            err = sbeu_pkg::ERR_UNDER;
          end else begin
            tos_n = (cur.op == sbeu_pkg::OP_LNOT) ? {63'd0, tos == 64'd0} : ~tos;
          end
        end
        sbeu_pkg::OP_NORET: begin
          nr_set = 1'b1;
        end
        sbeu_pkg::OP_DROP: begin
          if (!sp_ge1) begin
            err = sbeu_pkg::ERR_UNDER;
          end else begin
            sp_n  = sp - 1'b1;
            tos_n = a;
          end
        end
        sbeu_pkg::OP_ADD, sbeu_pkg::OP_SUB, sbeu_pkg::OP_MUL, sbeu_pkg::OP_DIV,
        sbeu_pkg::OP_MOD, sbeu_pkg::OP_LT, sbeu_pkg::OP_LE, sbeu_pkg::OP_GT,
        sbeu_pkg::OP_GE, sbeu_pkg::OP_EQ, sbeu_pkg::OP_NE, sbeu_pkg::OP_SHL,
        sbeu_pkg::OP_SHR, sbeu_pkg::OP_OR, sbeu_pkg::OP_AND, sbeu_pkg::OP_XOR: begin
          if (!sp_ge2) begin
            err = sbeu_pkg::ERR_UNDER;
          end else if ((cur.op == sbeu_pkg::OP_DIV || cur.op == sbeu_pkg::OP_MOD) &&
                       b == 64'd0) begin
            err = sbeu_pkg::ERR_DIVZ;
          end else begin
            case (cur.op)
              sbeu_pkg::OP_ADD: r = a + b;
              sbeu_pkg::OP_SUB: r = a - b;
              sbeu_pkg::OP_MUL: begin
                md_op = 1'b1;
                r     = md_lo;
              end
              sbeu_pkg::OP_DIV: begin
                md_op = 1'b1;
                r     = (a[63] ^ b[63]) ? (64'd0 - md_lo) : md_lo;
              end
              sbeu_pkg::OP_MOD: begin
                md_op = 1'b1;
                r     = a[63] ? (64'd0 - md_hi) : md_hi;
              end
              sbeu_pkg::OP_LT:  r = {63'd0, $signed(a) < $signed(b)};
              sbeu_pkg::OP_LE:  r = {63'd0, $signed(a) <= $signed(b)};
              sbeu_pkg::OP_GT:  r = {63'd0, $signed(a) > $signed(b)};
              sbeu_pkg::OP_GE:  r = {63'd0, $signed(a) >= $signed(b)};
              sbeu_pkg::OP_EQ:  r = {63'd0, a == b};
              sbeu_pkg::OP_NE:  r = {63'd0, a != b};
              sbeu_pkg::OP_SHL: r = a << b[5:0];
              sbeu_pkg::OP_SHR: r = $unsigned($signed(a) >>> b[5:0]);
              sbeu_pkg::OP_OR:  r = a | b;
              sbeu_pkg::OP_AND: r = a & b;
              default:          r = a ^ b;
            endcase
            sp_n  = sp - 1'b1;
            tos_n = r;
          end
        end
        default: ;
      endcase
    end
  end

  assign md_start   = (state == ST_EXEC) && md_op && !md_have;
  assign commit     = (state == ST_EXEC) && !(md_op && !md_have) && out_free;
  assign clr_loc_on = (state == ST_CLEAR) && ({1'b0, cnt} < (CNTW+1)'(LOCALS_PER_FRAME));
  assign clr_glb_on = (state == ST_CLEAR) && clr_glob &&
                      ({1'b0, cnt} < (CNTW+1)'(GLOBAL_SLOTS));
  assign clr_end    = clr_glob ? (cnt == CNTW'(SWEEP - 1))
                               : (cnt == CNTW'(LOCALS_PER_FRAME - 1));
  assign loc_we     = clr_loc_on || (commit && var_we && cur.var_local);
  assign loc_wa     = clr_loc_on ? loc_ca : loc_ra;
  assign glb_we     = clr_glb_on || (commit && var_we && !cur.var_local);
  assign glb_wa     = clr_glb_on ? GIW'(cnt) : cur.gidx[GIW-1:0];

  sbeu_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .is_mul (md_is_mul),
    .a      (md_a),
    .b      (md_b),
    .done   (md_done),
    .res_lo (md_lo),
    .res_hi (md_hi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      cnt          <= '0;
      clr_glob     <= 1'b1;
      clr_level    <= '0;
      sp           <= '0;
      tos          <= '0;
      level        <= '0;
      noret        <= '0;
      pc           <= '0;
      start_addr   <= '0;
      restart_addr <= '0;
      halted       <= 1'b0;
      has_run      <= 1'b0;
      md_have      <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == sbeu_pkg::REG_START) begin
          start_addr <= cfg_data;
          if (!has_run) begin
            pc <= cfg_data;
          end
        end else if (cfg_index == sbeu_pkg::REG_RESTART) begin
          restart_addr <= cfg_data;
        end
      end
      if (res_valid && res_ready && !commit) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (md_start) begin
            state <= ST_MD;
          end else if (commit) begin
            md_have   <= 1'b0;
            has_run   <= 1'b1;
            sp        <= sp_n;
            tos       <= tos_n;
            level     <= lvl_n;
            halted    <= halt_n;
            pc        <= npc;
            res_valid <= 1'b1;
            if (err == sbeu_pkg::ERR_OK) begin
              if (nr_set) begin
                noret[level] <= 1'b1;
              end
              if (nr_clr) begin
                noret[nr_idx] <= 1'b0;
              end
            end
            if (clr_go && err == sbeu_pkg::ERR_OK) begin
              state     <= ST_CLEAR;
              cnt       <= '0;
              clr_glob  <= 1'b0;
              clr_level <= clr_lvl_c;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_MD: begin
          if (md_done) begin
            md_have <= 1'b1;
            state   <= ST_EXEC;
          end
        end
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (clr_end) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      cur <= q_item;
    end
    if (commit) begin
      res.next_pc     <= npc;
      res.top_value   <= (sp_n != '0) ? tos_n : 64'd0;
      res.stack_depth <= 9'(sp_n);
      res.halted      <= halt_n;
      res.error_code  <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      stk_rd <= stk_mem[SAW'(sp - SPW'(2))];
      loc_rd <= loc_mem[loc_ra];
      glb_rd <= glb_mem[cur.gidx[GIW-1:0]];
      ret_rd <= ret_mem[LVW'(level - 1'b1)];
    end
    if (commit && push_we) begin
      stk_mem[SAW'(sp - 1'b1)] <= tos;
    end
    if (loc_we) begin
      loc_mem[loc_wa] <= clr_loc_on ? 65'd0 : var_wd;
    end
    if (glb_we) begin
      glb_mem[glb_wa] <= clr_glb_on ? 65'd0 : var_wd;
    end
    if (commit && ret_we) begin
      ret_mem[level] <= cur.next_address;
    end
  end

endmodule

### design/stack_bytecode_execute_unit_core.sv
// ----------------------------------------------------------------------------
// stack_bytecode_execute_unit_core
// Executes one decoded 64-bit stack machine instruction per transaction.
// ----------------------------------------------------------------------------
// An instruction passes through the execute sequencer as queue pop, registered
// memory read, then execute and commit; multiply adds a start step, the three
// 32x32 partial products and a hand-back step, divide and modulo add the
// bit-serial divider (start, 64 quotient bits, hand-back). A call or a noreturn
// restart is followed by a clearing pass over the LOCALS_PER_FRAME entries of
// the called frame, or of the current frame on a restart, in the locals memory.
// After reset a clearing pass zeroes globals and the top-level frame before the
// first instruction is taken; configuration writes are taken during it. A
// two-entry queue and the front register accept new instructions while a
// result waits.
module stack_bytecode_execute_unit_core #(
  parameter int STACK_DEPTH      = sbeu_pkg::STACK_DEPTH_DEF,
  parameter int LOCALS_PER_FRAME = sbeu_pkg::LOCALS_DEF,
  parameter int GLOBAL_SLOTS     = sbeu_pkg::GLOBALS_DEF,
  parameter int CALL_DEPTH       = sbeu_pkg::CALL_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // req_type[5:0], operand[69:6], next_address[101:70], zero[103:102]
  input  logic [sbeu_pkg::IN_DATA_W-1:0]  s_tdata,
  // is_array
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // next_pc[31:0], top_value[95:32], stack_depth[104:96], halted[105],
  // error_code[108:106], zero[111:109]
  output logic [sbeu_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [sbeu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbeu_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic            fq_valid;
  logic            fq_ready;
  sbeu_pkg::item_t fq_item;
  logic            qb_valid;
  logic            qb_ready;
  sbeu_pkg::item_t qb_item;
  sbeu_pkg::res_t  res;

  sbeu_front #(
    .LOCALS_PER_FRAME (LOCALS_PER_FRAME),
    .GLOBAL_SLOTS     (GLOBAL_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  sbeu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  sbeu_back #(
    .STACK_DEPTH      (STACK_DEPTH),
    .LOCALS_PER_FRAME (LOCALS_PER_FRAME),
    .GLOBAL_SLOTS     (GLOBAL_SLOTS),
    .CALL_DEPTH       (CALL_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_item    (qb_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {3'd0, res.error_code, res.halted, res.stack_depth,
                    res.top_value, res.next_pc};

endmodule

### design/sbeu_checker.sv
// ----------------------------------------------------------------------------
// sbeu_checker
// Port-level checks of the stack bytecode execute unit, bound to the top.
// ----------------------------------------------------------------------------
module sbeu_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [sbeu_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                            s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [sbeu_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            cfg_we,
  input logic [sbeu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [sbeu_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic halt_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      halt_seen <= 1'b0;
    end else if (m_tvalid && m_tready && m_tdata[105]) begin
      halt_seen <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && halt_seen |-> m_tdata[105])
    else $error("halt flag dropped");

  a_halt_no_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[105] |-> m_tdata[108:106] == sbeu_pkg::ERR_OK)
    else $error("error reported while halted");

  a_err_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[108:106] <= sbeu_pkg::ERR_INDEX)
    else $error("unknown error code");

endmodule

bind stack_bytecode_execute_unit_core sbeu_checker u_sbeu_checker (.*);
